// ----- src/wfg_pkg.sv -----
// Shared types and constants for the wait-for graph cycle detector.
package wfg_pkg;

    localparam int unsigned OP_W = 3;
    localparam int unsigned ID_W = 9;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_EDGE = 3'd0,
        OP_DEL_EDGE = 3'd1,
        OP_DEL_NODE = 3'd2,
        OP_PATH     = 3'd3,
        OP_CYCLE    = 3'd4
    } t_op;

endpackage

// ----- src/wfg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wfg_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/wfg_pick.sv -----
// Picks the lowest pending node of the search frontier.
module wfg_pick #(
    parameter int unsigned NODES = 64
) (
    input  logic [NODES-1:0]         i_pend,
    output logic                     o_any,
    output logic [$clog2(NODES)-1:0] o_idx
);

    localparam int unsigned IW = $clog2(NODES);

    logic [NODES-1:0] lowest;
    logic [IW-1:0]    idx;

    // isolate lowest set bit, then encode the one-hot word
    assign lowest = i_pend & (~i_pend + NODES'(1));

    always_comb begin
        idx = '0;
        for (int i = 0; i < NODES; i++) begin
            if (lowest[i]) begin
                idx = idx | IW'(i);
            end
        end
    end

    assign o_any = |i_pend;
    assign o_idx = idx;

endmodule

// ----- src/wait_for_graph_cycle_detector.sv -----
// Wait-for graph: adjacency rows in RAM, edits by read-modify-write, reachability by BFS.
// Edge edits read the source row, then write it back modified; bad ids, equal-id path query or
// undefined op go straight to the result; remove node sweeps one row per cycle through the RAM
// read/write ports; path and cycle queries read one row per visited node, plus a bubble
// whenever the frontier waits on that row.
// One item at a time; synchronous reset clears per-row valid bits, so the graph is empty at once.
module wait_for_graph_cycle_detector #(
    parameter int unsigned NODES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [wfg_pkg::OP_W-1:0]         i_op,
    input  logic signed [wfg_pkg::ID_W-1:0]  i_src_node,
    input  logic signed [wfg_pkg::ID_W-1:0]  i_dst_node,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_found,
    output logic                             o_ids_valid
);

    localparam int unsigned IW  = $clog2(NODES);
    localparam int unsigned CW  = $clog2(NODES + 1);
    localparam int unsigned IDW = wfg_pkg::ID_W;
    localparam logic [IDW-1:0] NODES_ID = IDW'(NODES);
    localparam logic [CW-1:0]  NODES_CNT = CW'(NODES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_WR,
        S_SWEEP,
        S_BFS_START,
        S_BFS,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    wfg_pkg::t_op    r_op, n_op;
    logic [IW-1:0]   r_s, n_s;
    logic [IW-1:0]   r_d, n_d;
    logic [IW-1:0]   r_wr_addr, n_wr_addr;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_wr_pend, n_wr_pend;
    logic            r_inflight, n_inflight;
    logic            r_rd_vld, n_rd_vld;
    logic [NODES-1:0] r_reach, n_reach;
    logic [NODES-1:0] r_done, n_done;
    logic [NODES-1:0] r_row_vld, n_row_vld;
    logic            r_found, n_found;
    logic            r_ids, n_ids;
    logic            r_out_valid, n_out_valid;
    logic            r_out_found, n_out_found;
    logic            r_out_ids, n_out_ids;

    logic            ram_we, ram_re;
    logic [IW-1:0]   ram_waddr, ram_raddr;
    logic [NODES-1:0] ram_wdata, ram_rdata;
    logic [NODES-1:0] row, row_mod, pend;
    logic            pick_any;
    logic [IW-1:0]   pick_idx;
    logic            src_ok, dst_ok;
    logic [IW-1:0]   src_idx, dst_idx;

    wfg_ram #(
        .WIDTH (NODES),
        .DEPTH (NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign pend = r_reach & ~r_done;

    wfg_pick #(
        .NODES (NODES)
    ) u_pick (
        .i_pend (pend),
        .o_any  (pick_any),
        .o_idx  (pick_idx)
    );

    // negative ids have the sign bit set; the rest must stay below NODES
    assign src_ok  = !i_src_node[IDW-1] && ($unsigned(i_src_node) < NODES_ID);
    assign dst_ok  = !i_dst_node[IDW-1] && ($unsigned(i_dst_node) < NODES_ID);
    assign src_idx = i_src_node[IW-1:0];
    assign dst_idx = i_dst_node[IW-1:0];

    // a row never written reads as empty
    assign row = r_rd_vld ? ram_rdata : '0;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_s         = r_s;
        n_d         = r_d;
        n_wr_addr   = r_wr_addr;
        n_cnt       = r_cnt;
        n_wr_pend   = r_wr_pend;
        n_inflight  = r_inflight;
        n_rd_vld    = r_rd_vld;
        n_reach     = r_reach;
        n_done      = r_done;
        n_row_vld   = r_row_vld;
        n_found     = r_found;
        n_ids       = r_ids;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_ids   = r_out_ids;
        ram_we      = 1'b0;
        ram_waddr   = r_s;
        ram_wdata   = row;
        ram_re      = 1'b0;
        ram_raddr   = r_s;
        row_mod     = row;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = wfg_pkg::t_op'(i_op);
                    n_s     = src_idx;
                    n_d     = dst_idx;
                    n_found = 1'b0;
                    n_ids   = 1'b0;
                    n_state = S_DONE;
                    case (wfg_pkg::t_op'(i_op))
                        wfg_pkg::OP_ADD_EDGE, wfg_pkg::OP_DEL_EDGE: begin
                            if (src_ok && dst_ok) begin
                                n_ids   = 1'b1;
                                n_state = S_EDGE_RD;
                            end
                        end
                        wfg_pkg::OP_DEL_NODE: begin
                            if (src_ok) begin
                                n_ids     = 1'b1;
                                n_cnt     = '0;
                                n_wr_pend = 1'b0;
                                n_state   = S_SWEEP;
                            end
                        end
                        wfg_pkg::OP_PATH: begin
                            if (src_ok && dst_ok) begin
                                n_ids = 1'b1;
                                if (src_idx == dst_idx) begin
                                    n_found = 1'b1;
                                end else begin
                                    n_state = S_BFS_START;
                                end
                            end
                        end
                        wfg_pkg::OP_CYCLE: begin
                            if (src_ok) begin
                                n_ids   = 1'b1;
                                n_d     = src_idx;
                                n_state = S_BFS_START;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_EDGE_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_s;
                n_rd_vld  = r_row_vld[r_s];
                n_state   = S_EDGE_WR;
            end
            S_EDGE_WR: begin
                row_mod[r_d]   = (r_op == wfg_pkg::OP_ADD_EDGE);
                ram_we         = 1'b1;
                ram_waddr      = r_s;
                ram_wdata      = row_mod;
                n_row_vld[r_s] = 1'b1;
                n_state        = S_DONE;
            end
            S_SWEEP: begin
                // read row i while row i-1 is written back with column s cleared
                row_mod[r_s] = 1'b0;
                if (r_wr_pend) begin
                    ram_we               = 1'b1;
                    ram_waddr            = r_wr_addr;
                    ram_wdata            = (r_wr_addr == r_s) ? '0 : row_mod;
                    n_row_vld[r_wr_addr] = 1'b1;
                end
                if (r_cnt != NODES_CNT) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_cnt[IW-1:0];
                    n_rd_vld  = r_row_vld[r_cnt[IW-1:0]];
                    n_wr_addr = r_cnt[IW-1:0];
                    n_cnt     = r_cnt + CW'(1);
                    n_wr_pend = 1'b1;
                end else begin
                    n_wr_pend = 1'b0;
                    n_state   = S_DONE;
                end
            end
            S_BFS_START: begin
                ram_re     = 1'b1;
                ram_raddr  = r_s;
                n_rd_vld   = r_row_vld[r_s];
                n_reach    = '0;
                n_done     = '0;
                n_inflight = 1'b1;
                n_state    = S_BFS;
            end
            S_BFS: begin
                if (r_inflight) begin
                    n_reach = r_reach | row;
                end
                if (pick_any) begin
                    ram_re           = 1'b1;
                    ram_raddr        = pick_idx;
                    n_rd_vld         = r_row_vld[pick_idx];
                    n_done[pick_idx] = 1'b1;
                    n_inflight       = 1'b1;
                end else begin
                    n_inflight = 1'b0;
                    // frontier empty and nothing left in flight
                    if (!r_inflight) begin
                        n_found = r_reach[r_d];
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_ids   = r_ids;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_row_vld   <= '0;
            r_wr_pend   <= 1'b0;
            r_inflight  <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_row_vld   <= n_row_vld;
            r_wr_pend   <= n_wr_pend;
            r_inflight  <= n_inflight;
            r_rd_vld    <= n_rd_vld;
        end
        r_out_found <= n_out_found;
        r_out_ids   <= n_out_ids;
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_s       <= n_s;
        r_d       <= n_d;
        r_wr_addr <= n_wr_addr;
        r_cnt     <= n_cnt;
        r_reach   <= n_reach;
        r_done    <= n_done;
        r_found   <= n_found;
        r_ids     <= n_ids;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_ids_valid = r_out_ids;

endmodule

// ----- src/wfg_chk.sv -----
// Port-level checker for the wait-for graph cycle detector, bound to the top level.
module wfg_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_found,
    input logic i_ids_valid
);

    // reset always empties the result register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one item in work at a time: input closes right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // a found result only comes from in-range ids
    a_found_needs_ids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_found) |-> i_ids_valid)
        else $error("found set with bad ids");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_found) && $stable(i_ids_valid)))
        else $error("stalled result changed");

endmodule

bind wait_for_graph_cycle_detector wfg_chk u_wfg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_found     (o_found),
    .i_ids_valid (o_ids_valid)
);

// ----- sim/testbench.sv -----
// Testbench for the wait-for graph cycle detector: directed table, then random traffic.
module testbench;

    localparam int NODES       = 64;
    localparam int RAND_ITEMS  = 1850;
    localparam int CHUNK       = 50;
    localparam int CYCLE_LIMIT = 1_200_000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 2 * NODES + 8;
    localparam int MAX_REPORTS = 10;

    // op encodings the block must treat as no-ops
    localparam logic [wfg_pkg::OP_W-1:0] OP_RSVD_LO  = 3'd5;
    localparam logic [wfg_pkg::OP_W-1:0] OP_RSVD_MID = 3'd6;
    localparam logic [wfg_pkg::OP_W-1:0] OP_RSVD_HI  = 3'd7;

    typedef struct packed {
        logic found;
        logic ids_valid;
    } t_outcome;

    typedef struct packed {
        logic [wfg_pkg::OP_W-1:0] op;
        logic [wfg_pkg::ID_W-1:0] src;
        logic [wfg_pkg::ID_W-1:0] dst;
        logic                     preset;     // expected outcome given in the row
        logic                     want_found;
        logic                     want_valid;
    } t_dir_row;

    localparam int DIR_N = 27;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [wfg_pkg::OP_W-1:0]        i_op;
    logic signed [wfg_pkg::ID_W-1:0] i_src_node;
    logic signed [wfg_pkg::ID_W-1:0] i_dst_node;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic                            o_found;
    logic                            o_ids_valid;

    logic [NODES-1:0] wfg_rows [NODES];
    t_outcome         pending_results [$];
    t_dir_row         dir_tbl [DIR_N];

    int  mismatches;
    int  cycle_cnt;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_left;
    bit  hold_start;
    int  pool_base;
    int  pool_size;

    wait_for_graph_cycle_detector #(.NODES(NODES)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_src_node  (i_src_node),
        .i_dst_node  (i_dst_node),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_found     (o_found),
        .o_ids_valid (o_ids_valid)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- graph predictor ----------------

    function automatic bit decode_node(input logic [wfg_pkg::ID_W-1:0] raw, output int idx);
        idx = int'(raw);
        return !raw[wfg_pkg::ID_W-1] && (int'(raw) < NODES);
    endfunction

    // nodes reachable from start through one or more edges
    function automatic logic [NODES-1:0] reach_set(input int start);
        logic [NODES-1:0] reach;
        logic [NODES-1:0] visited;
        bit               grew;
        reach   = wfg_rows[start];
        visited = '0;
        grew    = 1'b1;
        while (grew) begin
            grew = 1'b0;
            for (int n = 0; n < NODES; n++) begin
                if (reach[n] && !visited[n]) begin
                    visited[n] = 1'b1;
                    reach      = reach | wfg_rows[n];
                    grew       = 1'b1;
                end
            end
        end
        return reach;
    endfunction

    function automatic t_outcome wfg_apply(input logic [wfg_pkg::OP_W-1:0] op,
                                           input logic [wfg_pkg::ID_W-1:0] src,
                                           input logic [wfg_pkg::ID_W-1:0] dst);
        t_outcome         res;
        int               s;
        int               d;
        bit               s_ok;
        bit               d_ok;
        logic [NODES-1:0] reach;
        s_ok = decode_node(src, s);
        d_ok = decode_node(dst, d);
        res  = '0;
        case (op)
            wfg_pkg::OP_ADD_EDGE, wfg_pkg::OP_DEL_EDGE: begin
                if (s_ok && d_ok) begin
                    wfg_rows[s][d] = (op == wfg_pkg::OP_ADD_EDGE);
                    res.ids_valid  = 1'b1;
                end
            end
            wfg_pkg::OP_DEL_NODE: begin
                if (s_ok) begin
                    wfg_rows[s] = '0;
                    for (int n = 0; n < NODES; n++)
                        wfg_rows[n][s] = 1'b0;
                    res.ids_valid = 1'b1;
                end
            end
            wfg_pkg::OP_PATH: begin
                if (s_ok && d_ok) begin
                    res.ids_valid = 1'b1;
                    if (s == d) begin
                        res.found = 1'b1;
                    end else begin
                        reach     = reach_set(s);
                        res.found = reach[d];
                    end
                end
            end
            wfg_pkg::OP_CYCLE: begin
                if (s_ok) begin
                    res.ids_valid = 1'b1;
                    reach         = reach_set(s);
                    res.found     = reach[s];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ---------------- input side ----------------

    task automatic offer_item(input logic [wfg_pkg::OP_W-1:0] op,
                              input logic [wfg_pkg::ID_W-1:0] src,
                              input logic [wfg_pkg::ID_W-1:0] dst, input bit preset,
                              input t_outcome preset_res);
        t_outcome predicted;
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_src_node <= src;
        i_dst_node <= dst;
        do @(posedge i_clk); while (!o_in_ready);
        // transfer taken at this edge
        predicted = wfg_apply(op, src, dst);
        pending_results.push_back(preset ? preset_res : predicted);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [wfg_pkg::ID_W-1:0] rand_id();
        if ($urandom_range(99) < 6) begin
            case ($urandom_range(2))
                0:       return {1'b1, 8'($urandom)};                      // negative
                1:       return wfg_pkg::ID_W'($urandom_range(255, NODES)); // too large
                default: return $urandom_range(1) ? 9'h100 : 9'h0FF;       // field extremes
            endcase
        end
        return wfg_pkg::ID_W'(pool_base + $urandom_range(pool_size - 1));
    endfunction

    function automatic logic [wfg_pkg::OP_W-1:0] rand_op();
        int r;
        r = $urandom_range(99);
        if (r < 30) return wfg_pkg::OP_ADD_EDGE;
        if (r < 42) return wfg_pkg::OP_DEL_EDGE;
        if (r < 46) return wfg_pkg::OP_DEL_NODE;
        if (r < 70) return wfg_pkg::OP_PATH;
        if (r < 97) return wfg_pkg::OP_CYCLE;
        return wfg_pkg::OP_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
    endfunction

    // ---------------- output side ----------------

    always @(negedge i_clk) begin
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_outcome want;
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("ERROR cycle %0d: result with nothing pending (found %b ids_valid %b)",
                             cycle_cnt, o_found, o_ids_valid);
                mismatches = mismatches + 1;
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found || o_ids_valid !== want.ids_valid) begin
                    if (mismatches < MAX_REPORTS)
                        $display("ERROR cycle %0d: found %b/%b ids_valid %b/%b (exp/got)",
                                 cycle_cnt, want.found, o_found, want.ids_valid, o_ids_valid);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        dir_tbl = '{
            '{wfg_pkg::OP_PATH,     9'h000, 9'h000, 1'b1, 1'b1, 1'b1},  // equal ids
            '{wfg_pkg::OP_CYCLE,    9'h000, 9'h000, 1'b1, 1'b0, 1'b1},  // empty graph
            '{wfg_pkg::OP_PATH,     9'h000, 9'h03F, 1'b1, 1'b0, 1'b1},
            '{wfg_pkg::OP_ADD_EDGE, 9'h000, 9'h03F, 1'b1, 1'b0, 1'b1},
            '{wfg_pkg::OP_ADD_EDGE, 9'h03F, 9'h000, 1'b1, 1'b0, 1'b1},
            '{wfg_pkg::OP_CYCLE,    9'h000, 9'h000, 1'b0, 1'b0, 1'b0},
            '{wfg_pkg::OP_PATH,     9'h03F, 9'h000, 1'b0, 1'b0, 1'b0},
            '{wfg_pkg::OP_ADD_EDGE, 9'h005, 9'h005, 1'b1, 1'b0, 1'b1},  // self edge
            '{wfg_pkg::OP_CYCLE,    9'h005, 9'h1FF, 1'b0, 1'b0, 1'b0},  // bad dst ignored
            '{wfg_pkg::OP_ADD_EDGE, 9'h100, 9'h001, 1'b1, 1'b0, 1'b0},  // most negative id
            '{wfg_pkg::OP_ADD_EDGE, 9'h001, 9'h0FF, 1'b1, 1'b0, 1'b0},  // largest id
            '{wfg_pkg::OP_PATH,     9'h1FF, 9'h000, 1'b1, 1'b0, 1'b0},
            '{wfg_pkg::OP_PATH,     9'h040, 9'h000, 1'b1, 1'b0, 1'b0},  // first id past graph
            '{wfg_pkg::OP_CYCLE,    9'h040, 9'h000, 1'b1, 1'b0, 1'b0},
            '{wfg_pkg::OP_PATH,     9'h03F, 9'h03F, 1'b1, 1'b1, 1'b1},
            '{wfg_pkg::OP_ADD_EDGE, 9'h001, 9'h002, 1'b1, 1'b0, 1'b1},
            '{wfg_pkg::OP_ADD_EDGE, 9'h002, 9'h03F, 1'b1, 1'b0, 1'b1},
            '{wfg_pkg::OP_PATH,     9'h001, 9'h000, 1'b0, 1'b0, 1'b0},  // three hops
            '{wfg_pkg::OP_DEL_NODE, 9'h000, 9'h100, 1'b1, 1'b0, 1'b1},  // bad dst ignored
            '{wfg_pkg::OP_CYCLE,    9'h03F, 9'h100, 1'b0, 1'b0, 1'b0},
            '{wfg_pkg::OP_DEL_EDGE, 9'h005, 9'h005, 1'b1, 1'b0, 1'b1},
            '{wfg_pkg::OP_CYCLE,    9'h005, 9'h005, 1'b0, 1'b0, 1'b0},
            '{wfg_pkg::OP_DEL_EDGE, 9'h002, 9'h1FF, 1'b1, 1'b0, 1'b0},
            '{wfg_pkg::OP_DEL_NODE, 9'h0FF, 9'h000, 1'b1, 1'b0, 1'b0},
            '{OP_RSVD_LO,           9'h001, 9'h002, 1'b1, 1'b0, 1'b0},
            '{OP_RSVD_MID,          9'h002, 9'h03F, 1'b1, 1'b0, 1'b0},
            '{OP_RSVD_HI,           9'h03F, 9'h001, 1'b1, 1'b0, 1'b0}
        };

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = wfg_pkg::OP_ADD_EDGE;
        i_src_node    = '0;
        i_dst_node    = '0;
        i_out_ready   = 1'b0;
        mismatches    = 0;
        cycle_cnt     = 0;
        hold_left     = 0;
        hold_start    = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 70;
        for (int n = 0; n < NODES; n++)
            wfg_rows[n] = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tbl[k])
            offer_item(dir_tbl[k].op, dir_tbl[k].src, dir_tbl[k].dst, dir_tbl[k].preset,
                       '{dir_tbl[k].want_found, dir_tbl[k].want_valid});
        drain_results();

        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k == RAND_ITEMS / 3) begin
                drain_results();
                send_idle_pct = 70;
                recv_idle_pct = 13;
            end
            if (k == 2 * RAND_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long output stall while inputs keep coming
            if (k == 2 * RAND_ITEMS / 3 + 100)
                hold_start = 1'b1;
            if (k % CHUNK == 0) begin
                // dense small pools give paths and cycles, the full range keeps the rest honest
                case ($urandom_range(4))
                    0:       pool_size = 2;
                    1:       pool_size = 4;
                    2:       pool_size = 8;
                    3:       pool_size = 16;
                    default: pool_size = NODES;
                endcase
                pool_base = $urandom_range(NODES - pool_size);
            end
            offer_item(rand_op(), rand_id(), rand_id(), 1'b0, '0);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
